// ===== rtl/tbk_pkg.sv =====
// ----------------------------------------------------------------------------
// tbk_pkg
// Shared types, codes and default sizes for the countdown timer bank.
// ----------------------------------------------------------------------------
package tbk_pkg;

    // default sizes
    localparam int NUM_COUNTDOWNS_DEF = 8;
    localparam int NUM_TRIGGERS_DEF   = 8;
    localparam int COUNT_BITS_DEF     = 16;

    // fixed field widths
    localparam int COMMAND_W     = 3;
    localparam int SLOT_INDEX_W  = 3;
    localparam int TIMEOUT_W     = 16;
    localparam int EVENT_KIND_W  = 2;
    localparam int EVENT_INDEX_W = 3;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 8;

    // command codes
    typedef enum logic [COMMAND_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_LOAD     = 3'd1,
        CMD_CLEAR    = 3'd2,
        CMD_TRIG_SET = 3'd3,
        CMD_TRIG_REM = 3'd4
    } cmd_t;

    // event kinds
    typedef enum logic [EVENT_KIND_W-1:0] {
        EV_DONE    = 2'd0,
        EV_EXPIRED = 2'd1,
        EV_FIRED   = 2'd2
    } event_kind_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    // strobes from the controller to every cell
    typedef struct packed {
        logic dec;       // running tick accepted: decrement, inject token
        logic load;      // load command accepted
        logic clear;     // clear command accepted
        logic trig_set;  // register trigger accepted
        logic trig_rem;  // remove trigger accepted
        logic step;      // token moves one cell on
    } bank_ctl_t;

    // summary of the cell row for the controller
    typedef struct packed {
        logic hit;          // token cell has an event to report
        logic active;       // something stays active after a decrement
        logic cd_in_range;  // addressed countdown slot exists
        logic tr_in_range;  // addressed trigger slot exists
    } bank_sts_t;

endpackage

// ===== rtl/tbk_cd_cell.sv =====
// ----------------------------------------------------------------------------
// tbk_cd_cell
// One countdown slot: holds its count, flags expiry and passes the scan token.
// ----------------------------------------------------------------------------
module tbk_cd_cell
    import tbk_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bank_ctl_t            ctl,
    input  logic                 sel,
    input  logic [TIMEOUT_W-1:0] timeout,
    input  logic                 token_in,
    output logic                 token_out,
    output logic                 hit,
    output logic                 stays_active
);

    localparam logic [31:0] COUNT_MAX = 32'((33'(1) << COUNT_BITS) - 33'(1));

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  expired_reg;
    logic                  expired_next;
    logic                  token_reg;
    logic                  token_next;
    logic [31:0]           timeout_ext;
    logic [COUNT_BITS-1:0] load_value;

    // saturate the timeout to the count range
    always_comb
    begin
        timeout_ext = 32'(timeout);
        if (timeout_ext > COUNT_MAX)
            load_value = COUNT_MAX[COUNT_BITS-1:0];
        else
            load_value = timeout_ext[COUNT_BITS-1:0];
    end

    // count and expiry flag
    always_comb
    begin
        count_next   = count_reg;
        expired_next = expired_reg;
        if (ctl.load && sel)
            count_next = load_value;
        else if (ctl.clear && sel)
            count_next = '0;
        else if (ctl.dec)
        begin
            expired_next = (count_reg == COUNT_BITS'(1));
            if (count_reg != '0)
                count_next = count_reg - COUNT_BITS'(1);
        end
    end

    // token moves on at walk start and at each step
    assign token_next = (ctl.dec || ctl.step) ? token_in : token_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            expired_reg <= 1'b0;
            token_reg   <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            expired_reg <= expired_next;
            token_reg   <= token_next;
        end
    end

    assign token_out    = token_reg;
    assign hit          = token_reg && expired_reg;
    assign stays_active = (count_reg > COUNT_BITS'(1));

endmodule

// ===== rtl/tbk_trig_cell.sv =====
// ----------------------------------------------------------------------------
// tbk_trig_cell
// One trigger slot: holds its presence bit and passes the scan token.
// ----------------------------------------------------------------------------
module tbk_trig_cell
    import tbk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bank_ctl_t ctl,
    input  logic      sel,
    input  logic      token_in,
    output logic      token_out,
    output logic      hit,
    output logic      present
);

    logic present_reg;
    logic present_next;
    logic token_reg;
    logic token_next;

    // register and remove
    always_comb
    begin
        present_next = present_reg;
        if (ctl.trig_set && sel)
            present_next = 1'b1;
        else if (ctl.trig_rem && sel)
            present_next = 1'b0;
    end

    assign token_next = (ctl.dec || ctl.step) ? token_in : token_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            token_reg   <= 1'b0;
        end
        else
        begin
            present_reg <= present_next;
            token_reg   <= token_next;
        end
    end

    assign token_out = token_reg;
    assign hit       = token_reg && present_reg;
    assign present   = present_reg;

endmodule

// ===== rtl/tbk_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbk_ctrl
// Command decode, run flag, scan sequencer and output register.
// ----------------------------------------------------------------------------
module tbk_ctrl
    import tbk_pkg::*;
#(
    parameter int NUM_COUNTDOWNS = NUM_COUNTDOWNS_DEF,
    parameter int NUM_TRIGGERS   = NUM_TRIGGERS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [COMMAND_W-1:0]     command,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [EVENT_KIND_W-1:0]  event_kind,
    output logic [EVENT_INDEX_W-1:0] event_index,
    output logic                     running,
    output logic                     last,
    output bank_ctl_t                ctl,
    input  bank_sts_t                sts
);

    localparam int TOTAL = NUM_COUNTDOWNS + NUM_TRIGGERS;
    localparam int IDX_W = $clog2(TOTAL);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TOTAL - 1);

    state_t                   state_reg;
    state_t                   state_next;
    logic [IDX_W-1:0]         walk_idx_reg;
    logic [IDX_W-1:0]         walk_idx_next;
    logic                     running_reg;
    logic                     running_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    event_kind_t              m_kind_reg;
    event_kind_t              m_kind_next;
    logic [EVENT_INDEX_W-1:0] m_index_reg;
    logic [EVENT_INDEX_W-1:0] m_index_next;
    logic                     m_last_reg;
    logic                     m_last_next;
    logic                     m_running_reg;
    logic                     m_running_next;
    cmd_t                     cmd;
    logic                     accept;
    logic                     can_emit;
    logic                     in_cd_part;
    logic [31:0]              pos32;

    assign cmd      = cmd_t'(command);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign can_emit = !m_valid_reg || m_tready;

    // slot number of the token position within its own group
    assign in_cd_part = (32'(walk_idx_reg) < NUM_COUNTDOWNS);
    assign pos32      = in_cd_part ? 32'(walk_idx_reg)
                                   : 32'(walk_idx_reg) - 32'(NUM_COUNTDOWNS);

    // next state, cell strobes and output register loading
    always_comb
    begin
        state_next     = state_reg;
        walk_idx_next  = walk_idx_reg;
        running_next   = running_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_kind_next    = m_kind_reg;
        m_index_next   = m_index_reg;
        m_last_next    = m_last_reg;
        m_running_next = m_running_reg;
        ctl            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DONE;
                    unique case (cmd)
                        CMD_TICK:
                        begin
                            if (running_reg)
                            begin
                                ctl.dec       = 1'b1;
                                running_next  = sts.active;
                                walk_idx_next = '0;
                                state_next    = ST_WALK;
                            end
                        end
                        CMD_LOAD:
                        begin
                            ctl.load = 1'b1;
                            if (sts.cd_in_range)
                                running_next = 1'b1;
                        end
                        CMD_CLEAR:
                            ctl.clear = 1'b1;
                        CMD_TRIG_SET:
                        begin
                            ctl.trig_set = 1'b1;
                            if (sts.tr_in_range)
                                running_next = 1'b1;
                        end
                        CMD_TRIG_REM:
                            ctl.trig_rem = 1'b1;
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // hold the token on a hit until the output register is free
                if (!sts.hit || can_emit)
                begin
                    ctl.step = 1'b1;
                    if (sts.hit)
                    begin
                        m_valid_next   = 1'b1;
                        m_kind_next    = in_cd_part ? EV_EXPIRED : EV_FIRED;
                        m_index_next   = pos32[EVENT_INDEX_W-1:0];
                        m_last_next    = 1'b0;
                        m_running_next = running_reg;
                    end
                    if (walk_idx_reg == LAST_POS)
                        state_next = ST_DONE;
                    else
                        walk_idx_next = walk_idx_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (can_emit)
                begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = EV_DONE;
                    m_index_next   = '0;
                    m_last_next    = 1'b1;
                    m_running_next = running_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            walk_idx_reg <= '0;
            running_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_idx_reg <= walk_idx_next;
            running_reg  <= running_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        m_kind_reg    <= m_kind_next;
        m_index_reg   <= m_index_next;
        m_last_reg    <= m_last_next;
        m_running_reg <= m_running_next;
    end

    assign m_tvalid    = m_valid_reg;
    assign event_kind  = m_kind_reg;
    assign event_index = m_index_reg;
    assign running     = m_running_reg;
    assign last        = m_last_reg;

    // a running tick always starts a scan
    a_tick_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_TICK) && running_reg) |=> (state_reg == ST_WALK))
        else $error("running tick did not start a scan");

    // the token is only in the row while scanning
    a_no_stray_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WALK) |-> !sts.hit)
        else $error("event reported outside a scan");

    // the closing result follows a free output slot in the done state
    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && can_emit) |=> (m_tvalid && last))
        else $error("closing result not loaded");

    // the scan position stays inside the row
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (walk_idx_reg <= LAST_POS))
        else $error("scan position beyond the last slot");

endmodule

// ===== rtl/countdown_timer_bank.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_bank
// Bank of one-shot countdown slots and per-tick triggers with auto run/stop.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  s_*     | in        | tuser: command; tdata: slot_index, timeout
//  m_*     | out       | tuser: event_kind; tdata: event_index, running; tlast
//
//  Each command, and a tick while stopped, goes from idle to the done state,
//  which loads the closing beat once the output register is free and returns
//  to idle; s_tready is high only in idle. A tick while running first walks
//  a scan token along the cell row, one slot per cycle unless held on a hit.
//  Each event beat held back by m_tready stalls the token for that cycle.
//  Reset clears all counts, triggers and the run flag; no clearing pass.
// ----------------------------------------------------------------------------
module countdown_timer_bank
    import tbk_pkg::*;
#(
    parameter int NUM_COUNTDOWNS = NUM_COUNTDOWNS_DEF,
    parameter int NUM_TRIGGERS   = NUM_TRIGGERS_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,  // slot_index[2:0], timeout[18:3]
    input  logic [COMMAND_W-1:0]    s_tuser,  // command[2:0]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,  // event_index[2:0], running[3]
    output logic [EVENT_KIND_W-1:0] m_tuser,  // event_kind[1:0]
    output logic                    m_tlast
);

    logic [SLOT_INDEX_W-1:0]  slot_index;
    logic [TIMEOUT_W-1:0]     timeout;
    logic [EVENT_INDEX_W-1:0] event_index;
    logic                     running;
    bank_ctl_t                ctl;
    bank_sts_t                sts;
    logic [NUM_COUNTDOWNS-1:0] cd_sel;
    logic [NUM_COUNTDOWNS-1:0] cd_tok;
    logic [NUM_COUNTDOWNS-1:0] cd_hit;
    logic [NUM_COUNTDOWNS-1:0] cd_act;
    logic [NUM_TRIGGERS-1:0]   tr_sel;
    logic [NUM_TRIGGERS-1:0]   tr_tok;
    logic [NUM_TRIGGERS-1:0]   tr_hit;
    logic [NUM_TRIGGERS-1:0]   tr_act;

    // unpack the input beat
    assign slot_index = s_tdata[SLOT_INDEX_W-1:0];
    assign timeout    = s_tdata[SLOT_INDEX_W +: TIMEOUT_W];

    // countdown cell row
    for (genvar i = 0; i < NUM_COUNTDOWNS; i++)
    begin : g_cd
        logic tok_in;
        assign cd_sel[i] = (32'(slot_index) == i);
        if (i == 0)
        begin : g_head
            assign tok_in = ctl.dec;
        end
        else
        begin : g_link
            assign tok_in = cd_tok[i-1];
        end
        tbk_cd_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .sel          (cd_sel[i]),
            .timeout      (timeout),
            .token_in     (tok_in),
            .token_out    (cd_tok[i]),
            .hit          (cd_hit[i]),
            .stays_active (cd_act[i])
        );
    end

    // trigger cell row, fed by the last countdown cell
    for (genvar j = 0; j < NUM_TRIGGERS; j++)
    begin : g_tr
        logic tok_in;
        assign tr_sel[j] = (32'(slot_index) == j);
        if (j == 0)
        begin : g_head
            assign tok_in = cd_tok[NUM_COUNTDOWNS-1];
        end
        else
        begin : g_link
            assign tok_in = tr_tok[j-1];
        end
        tbk_trig_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .sel       (tr_sel[j]),
            .token_in  (tok_in),
            .token_out (tr_tok[j]),
            .hit       (tr_hit[j]),
            .present   (tr_act[j])
        );
    end

    // row summary
    assign sts.hit         = (|cd_hit) || (|tr_hit);
    assign sts.active      = (|cd_act) || (|tr_act);
    assign sts.cd_in_range = |cd_sel;
    assign sts.tr_in_range = |tr_sel;

    tbk_ctrl #(
        .NUM_COUNTDOWNS (NUM_COUNTDOWNS),
        .NUM_TRIGGERS   (NUM_TRIGGERS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .command     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .event_kind  (m_tuser),
        .event_index (event_index),
        .running     (running),
        .last        (m_tlast),
        .ctl         (ctl),
        .sts         (sts)
    );

    // pack the output beat
    assign m_tdata = {{(M_TDATA_W - EVENT_INDEX_W - 1){1'b0}}, running, event_index};

endmodule

// ===== tb/tb_countdown_timer_bank.sv =====
// ----------------------------------------------------------------------------
// tb_countdown_timer_bank
// Self-checking bench for the countdown timer bank. Commands go in on the
// slave stream and a local model of the counts, triggers and run flag predicts
// every event beat. Each beat on the master stream is checked in order against
// the queue of predicted events. Random idling and stalls run on both sides.
// ----------------------------------------------------------------------------
module tb_countdown_timer_bank;
    import tbk_pkg::*;

    // spare command codes that the bank must ignore
    localparam logic [COMMAND_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [COMMAND_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam int RANDOM_ITEMS      = 160;
    localparam int SINK_HOLD_CYCLES  = 200;
    localparam int LIMIT_CYCLES      = 400000;
    localparam int SETTLE_CYCLES     = NUM_COUNTDOWNS_DEF + NUM_TRIGGERS_DEF + 8;
    localparam int IDLE_PERCENT      = 35;

    typedef struct {
        event_kind_t                kind;
        logic [EVENT_INDEX_W-1:0]   index;
        logic                       running;
        logic                       last;
    } event_beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [S_TDATA_W-1:0]       s_tdata = '0;
    logic [COMMAND_W-1:0]       s_tuser = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [M_TDATA_W-1:0]       m_tdata;
    logic [EVENT_KIND_W-1:0]    m_tuser;
    logic                       m_tlast;

    // local copy of the bank state
    logic [COUNT_BITS_DEF-1:0]  count_left [NUM_COUNTDOWNS_DEF];
    logic [NUM_TRIGGERS_DEF-1:0] trig_mask = '0;
    logic                       bank_on = 1'b0;

    event_beat_t                expected_events [$];
    int                         error_count = 0;
    int                         cycle_count = 0;

    // idling controls, written by the test sequence only
    bit                         src_idle_on = 1'b1;
    bit                         sink_idle_on = 1'b1;
    int                         hold_token = 0;

    countdown_timer_bank u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        error_count++;
    endtask

    // work out the event beats that one command causes
    task automatic predict_events(input logic [COMMAND_W-1:0] cmd,
                                  input logic [SLOT_INDEX_W-1:0] idx,
                                  input logic [TIMEOUT_W-1:0] tmo);
        event_beat_t pending [$];
        event_beat_t beat;
        logic        still_active;
        still_active = 1'b0;
        beat.running = 1'b0;
        beat.last = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                if (bank_on)
                begin
                    for (int i = 0; i < NUM_COUNTDOWNS_DEF; i++)
                    begin
                        if (count_left[i] != '0)
                        begin
                            count_left[i] = count_left[i] - 1'b1;
                            if (count_left[i] == '0)
                            begin
                                beat.kind = EV_EXPIRED;
                                beat.index = EVENT_INDEX_W'(i);
                                pending.push_back(beat);
                            end
                            else
                                still_active = 1'b1;
                        end
                    end
                    for (int i = 0; i < NUM_TRIGGERS_DEF; i++)
                    begin
                        if (trig_mask[i])
                        begin
                            beat.kind = EV_FIRED;
                            beat.index = EVENT_INDEX_W'(i);
                            pending.push_back(beat);
                            still_active = 1'b1;
                        end
                    end
                    if (!still_active)
                        bank_on = 1'b0;
                end
            end
            CMD_LOAD:
            begin
                if (idx < NUM_COUNTDOWNS_DEF)
                begin
                    count_left[idx] = COUNT_BITS_DEF'(tmo);
                    bank_on = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                if (idx < NUM_COUNTDOWNS_DEF)
                    count_left[idx] = '0;
            end
            CMD_TRIG_SET:
            begin
                if (idx < NUM_TRIGGERS_DEF)
                begin
                    trig_mask[idx] = 1'b1;
                    bank_on = 1'b1;
                end
            end
            CMD_TRIG_REM:
            begin
                if (idx < NUM_TRIGGERS_DEF)
                    trig_mask[idx] = 1'b0;
            end
            default:
            begin
            end
        endcase
        // closing beat
        beat.kind = EV_DONE;
        beat.index = '0;
        pending.push_back(beat);
        foreach (pending[k])
        begin
            pending[k].running = bank_on;
            pending[k].last = (k == pending.size() - 1);
            expected_events.push_back(pending[k]);
        end
    endtask

    // offer one command beat and wait for it to be taken
    task automatic send_item(input logic [COMMAND_W-1:0] cmd,
                             input logic [SLOT_INDEX_W-1:0] idx,
                             input logic [TIMEOUT_W-1:0] tmo);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(99) < IDLE_PERCENT)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= S_TDATA_W'({tmo, idx});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_events(cmd, idx, tmo);
    endtask

    // stop offering and wait for every predicted beat
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
    endtask

    // output side: check each beat, then pick the next tready
    always @(posedge clk)
    begin : sink_side
        int          hold_left;
        int          hold_seen;
        event_beat_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_events.size() == 0)
                report_mismatch($sformatf("unexpected beat kind %0d index %0d",
                                          m_tuser, m_tdata[2:0]));
            else
            begin
                want = expected_events.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d",
                                              m_tuser, want.kind));
                if (m_tdata[2:0] !== want.index)
                    report_mismatch($sformatf("event_index %0d, want %0d",
                                              m_tdata[2:0], want.index));
                if (m_tdata[3] !== want.running)
                    report_mismatch($sformatf("running %0b, want %0b",
                                              m_tdata[3], want.running));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %0b, want %0b",
                                              m_tlast, want.last));
            end
        end
        // long hold-off on request
        if (hold_seen != hold_token)
        begin
            hold_seen = hold_token;
            hold_left = SINK_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(sink_idle_on && $urandom_range(99) < IDLE_PERCENT);
    end

    // extremes of the fields, every command and the special cases
    task automatic test_directed();
        // tick while stopped, then spare codes
        send_item(CMD_TICK, 3'd0, 16'h0000);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_item(COMMAND_W'(c), 3'd7, 16'hFFFF);
        // zero timeout starts the bank, the next tick stops it
        send_item(CMD_LOAD, 3'd0, 16'h0000);
        send_item(CMD_TICK, 3'd0, 16'h0000);
        // mixed counts and triggers
        send_item(CMD_LOAD, 3'd7, 16'hFFFF);
        send_item(CMD_LOAD, 3'd1, 16'h0001);
        send_item(CMD_LOAD, 3'd2, 16'h5555);
        send_item(CMD_TRIG_SET, 3'd0, 16'h0000);
        send_item(CMD_TRIG_SET, 3'd7, 16'h0000);
        send_item(CMD_TICK, 3'd0, 16'h0000);
        send_item(CMD_TRIG_REM, 3'd0, 16'h0000);
        send_item(CMD_CLEAR, 3'd7, 16'h0000);
        send_item(CMD_CLEAR, 3'd2, 16'h0000);
        send_item(CMD_LOAD, 3'd4, 16'hAAAA);
        send_item(CMD_TICK, 3'd0, 16'h0000);
        send_item(CMD_TRIG_REM, 3'd7, 16'h0000);
        send_item(CMD_CLEAR, 3'd4, 16'h0000);
        // one count left, runs out and stops the bank
        send_item(CMD_LOAD, 3'd3, 16'h0002);
        send_item(CMD_TICK, 3'd0, 16'h0000);
        send_item(CMD_TICK, 3'd0, 16'h0000);
        send_item(CMD_TICK, 3'd0, 16'h0000);
    endtask

    // full bank tick while the output is held off, then a drain pause
    task automatic test_back_pressure();
        hold_token++;
        for (int i = 0; i < NUM_COUNTDOWNS_DEF; i++)
            send_item(CMD_LOAD, SLOT_INDEX_W'(i), 16'h0001);
        for (int i = 0; i < NUM_TRIGGERS_DEF; i++)
            send_item(CMD_TRIG_SET, SLOT_INDEX_W'(i), 16'h0000);
        send_item(CMD_TICK, 3'd0, 16'h0000);
        send_item(CMD_TICK, 3'd0, 16'h0000);
        drain_results();
        for (int i = 0; i < NUM_TRIGGERS_DEF; i++)
            send_item(CMD_TRIG_REM, SLOT_INDEX_W'(i), 16'h0000);
        send_item(CMD_TICK, 3'd0, 16'h0000);
    endtask

    // weighted random command mix, mostly short counts so expiries happen
    task automatic test_random();
        logic [COMMAND_W-1:0]    cmd;
        logic [SLOT_INDEX_W-1:0] idx;
        logic [TIMEOUT_W-1:0]    tmo;
        int                      pick;
        int                      sel;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // a long stretch with no idling on either side
            src_idle_on = !(n >= 90 && n < 140);
            sink_idle_on = src_idle_on;
            pick = $urandom_range(99);
            idx = SLOT_INDEX_W'($urandom_range(7));
            tmo = TIMEOUT_W'($urandom_range(65535));
            if (pick < 35)
                cmd = CMD_TICK;
            else if (pick < 65)
            begin
                cmd = CMD_LOAD;
                sel = $urandom_range(99);
                if (sel < 70)
                    tmo = TIMEOUT_W'($urandom_range(1, 6));
                else if (sel < 85)
                    tmo = '0;
            end
            else if (pick < 75)
                cmd = CMD_CLEAR;
            else if (pick < 87)
                cmd = CMD_TRIG_SET;
            else if (pick < 97)
                cmd = CMD_TRIG_REM;
            else
                cmd = COMMAND_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            send_item(cmd, idx, tmo);
        end
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // test sequence
    initial
    begin
        foreach (count_left[i])
            count_left[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_pressure();
        test_random();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_events.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tbk_pkg.sv
rtl/tbk_cd_cell.sv
rtl/tbk_trig_cell.sv
rtl/tbk_ctrl.sv
rtl/countdown_timer_bank.sv
tb/tb_countdown_timer_bank.sv
